/* rtl/xlf_pkg.sv */
`default_nettype none

package xlf_pkg;

  // Operation codes of the recorded instruction.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBB = 4'd3,
    OP_NEG = 4'd4,
    OP_INC = 4'd5,
    OP_DEC = 4'd6,
    OP_DAA = 4'd7
  } op_t;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ByteWidth = 8;

  // Sign bit values and masks at each operand size.
  localparam logic [DataWidth-1:0] SignWord  = 16'h8000;
  localparam logic [DataWidth-1:0] SignByte  = 16'h0080;
  localparam logic [DataWidth-1:0] MaxWord   = 16'h7FFF;
  localparam logic [DataWidth-1:0] MaxByte   = 16'h007F;
  localparam logic [DataWidth-1:0] MaskWord  = 16'hFFFF;
  localparam logic [DataWidth-1:0] MaskByte  = 16'h00FF;
  localparam int unsigned          AuxBit    = 4;
  localparam logic [3:0]           NibbleAll = 4'hF;

  // One recorded operation as it is held in the input register.
  typedef struct packed {
    logic [3:0]           req_type;
    logic                 wide;
    logic [DataWidth-1:0] first_operand;
    logic [DataWidth-1:0] second_operand;
    logic [DataWidth-1:0] op_result;
  } req_t;

  // The six evaluated status flags.
  typedef struct packed {
    logic carry_flag;
    logic parity_flag;
    logic aux_carry_flag;
    logic zero_flag;
    logic sign_flag;
    logic overflow_flag;
  } flags_t;

endpackage

`default_nettype wire

/* rtl/xlf_ifs.sv */
`default_nettype none

// Request channel: one recorded operation per transfer.
interface xlf_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic        wide;
  logic [15:0] first_operand;
  logic [15:0] second_operand;
  logic [15:0] op_result;

  modport source (output valid, output req_type, output wide, output first_operand,
                  output second_operand, output op_result, input ready);
  modport sink   (input valid, input req_type, input wide, input first_operand,
                  input second_operand, input op_result, output ready);
endinterface

// Flags channel: one set of six status flags per transfer.
interface xlf_flags_if;
  logic valid;
  logic ready;
  logic carry_flag;
  logic parity_flag;
  logic aux_carry_flag;
  logic zero_flag;
  logic sign_flag;
  logic overflow_flag;

  modport source (output valid, output carry_flag, output parity_flag,
                  output aux_carry_flag, output zero_flag, output sign_flag,
                  output overflow_flag, input ready);
  modport sink   (input valid, input carry_flag, input parity_flag,
                  input aux_carry_flag, input zero_flag, input sign_flag,
                  input overflow_flag, output ready);
endinterface

`default_nettype wire

/* rtl/xlf_flag_calc.sv */
`default_nettype none

module xlf_flag_calc (
  input  wire xlf_pkg::req_t req_in,
  output xlf_pkg::flags_t    flags
);
  import xlf_pkg::*;

  logic [DataWidth-1:0] mask;
  logic [DataWidth-1:0] sign_val;
  logic [DataWidth-1:0] max_val;
  logic [DataWidth-1:0] a;
  logic [DataWidth-1:0] b;
  logic [DataWidth-1:0] r;
  logic [DataWidth-1:0] add_ovf;
  logic [DataWidth-1:0] sub_ovf;
  logic                 add_of;
  logic                 sub_of;
  logic                 aux_xor;
  logic                 cf;
  logic                 af;
  logic                 of;

  // Cut operands and result to the operand size.
  assign mask     = req_in.wide ? MaskWord : MaskByte;
  assign sign_val = req_in.wide ? SignWord : SignByte;
  assign max_val  = req_in.wide ? MaxWord  : MaxByte;
  assign a        = req_in.first_operand  & mask;
  assign b        = req_in.second_operand & mask;
  assign r        = req_in.op_result      & mask;

  // Shared overflow and auxiliary carry terms for the add and subtract groups.
  assign add_ovf = ~(a ^ b) & (b ^ r);
  assign sub_ovf = (a ^ b) & (a ^ r);
  assign add_of  = req_in.wide ? add_ovf[DataWidth-1] : add_ovf[ByteWidth-1];
  assign sub_of  = req_in.wide ? sub_ovf[DataWidth-1] : sub_ovf[ByteWidth-1];
  assign aux_xor = a[AuxBit] ^ b[AuxBit] ^ r[AuxBit];

  // Per-operation rules for carry, auxiliary carry and overflow.
  always_comb begin
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    case (op_t'(req_in.req_type))
      OP_ADD: begin
        cf = r < a;
        af = aux_xor;
        of = add_of;
      end
      OP_ADC: begin
        cf = r <= a;
        af = aux_xor;
        of = add_of;
      end
      OP_SUB: begin
        cf = a < b;
        af = aux_xor;
        of = sub_of;
      end
      OP_SBB: begin
        cf = (a < r) || (b == mask);
        af = aux_xor;
        of = sub_of;
      end
      OP_NEG: begin
        cf = r != '0;
        af = r[3:0] != 4'h0;
        of = r == sign_val;
      end
      OP_INC: begin
        af = r[3:0] == 4'h0;
        of = r == sign_val;
      end
      OP_DEC: begin
        af = r[3:0] == NibbleAll;
        of = r == max_val;
      end
      OP_DAA: begin
        cf = a != '0;
        af = b != '0;
      end
      default: begin
        cf = 1'b0;
        af = 1'b0;
        of = 1'b0;
      end
    endcase
  end

  // Parity, zero and sign follow the result alone; other flags as above.
  always_comb begin
    flags.carry_flag     = cf;
    flags.parity_flag    = ~^r[ByteWidth-1:0];
    flags.aux_carry_flag = af;
    flags.zero_flag      = r == '0;
    flags.sign_flag      = req_in.wide ? r[DataWidth-1] : r[ByteWidth-1];
    flags.overflow_flag  = of;
  end

endmodule

`default_nettype wire

/* rtl/x86_lazy_flags_eval.sv */
// An accepted request passes through the input register and then the result register to the output.
// Throughput: one request per cycle; the input register and the result register
// form a two-stage pipeline and stall only when the output is not taken.
// The flag logic between the two registers is a single pass of compares and XORs.
// Reset (rst, synchronous, active high) empties both stages; payload is not reset.
`default_nettype none

module x86_lazy_flags_eval (
  input  wire logic   clk,
  input  wire logic   rst,
  xlf_req_if.sink     req,
  xlf_flags_if.source rsp
);
  import xlf_pkg::*;

  req_t   stage_req;
  logic   stage_valid;
  flags_t flags_calc;
  flags_t result;
  logic   result_valid;
  logic   result_free;
  logic   stage_free;

  // A stage may load when it is empty or its content moves on this cycle.
  assign result_free = !result_valid || rsp.ready;
  assign stage_free  = !stage_valid || result_free;
  assign req.ready   = stage_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_free) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && stage_free) begin
      stage_req.req_type       <= req.req_type;
      stage_req.wide           <= req.wide;
      stage_req.first_operand  <= req.first_operand;
      stage_req.second_operand <= req.second_operand;
      stage_req.op_result      <= req.op_result;
    end
  end

  // Flag evaluation.
  xlf_flag_calc u_calc (
    .req_in (stage_req),
    .flags  (flags_calc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && result_free) begin
      result <= flags_calc;
    end
  end

  // Output channel.
  assign rsp.valid          = result_valid;
  assign rsp.carry_flag     = result.carry_flag;
  assign rsp.parity_flag    = result.parity_flag;
  assign rsp.aux_carry_flag = result.aux_carry_flag;
  assign rsp.zero_flag      = result.zero_flag;
  assign rsp.sign_flag      = result.sign_flag;
  assign rsp.overflow_flag  = result.overflow_flag;

endmodule

`default_nettype wire

/* rtl/xlf_checker.sv */
`default_nettype none

module xlf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic carry_flag,
  input wire logic parity_flag,
  input wire logic aux_carry_flag,
  input wire logic zero_flag,
  input wire logic sign_flag,
  input wire logic overflow_flag
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("flags valid right after reset");

  // An accepted request followed by a taken output passes through the input and result registers to the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
    else $error("accepted request did not reach the output in time");

  // A zero result has even parity and a clear sign.
  a_zero_consistent: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && zero_flag) |-> (parity_flag && !sign_flag))
    else $error("zero flag inconsistent with parity or sign");

  // A stalled output keeps its flags.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(carry_flag)
      && $stable(parity_flag) && $stable(aux_carry_flag) && $stable(zero_flag)
      && $stable(sign_flag) && $stable(overflow_flag)))
    else $error("stalled output changed");

endmodule

bind x86_lazy_flags_eval xlf_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .carry_flag     (rsp.carry_flag),
  .parity_flag    (rsp.parity_flag),
  .aux_carry_flag (rsp.aux_carry_flag),
  .zero_flag      (rsp.zero_flag),
  .sign_flag      (rsp.sign_flag),
  .overflow_flag  (rsp.overflow_flag)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import xlf_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned MaxWait     = 8;
  localparam int unsigned StallLimit  = 500;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned BurstItems  = 150;
  localparam int unsigned MixItems    = 1480;
  localparam int unsigned PhaseLength = 100;

  // Operation codes outside the defined set all behave as a plain operation.
  localparam logic [3:0] OpOther = 4'd8;
  localparam logic [3:0] OpTop   = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;

  xlf_req_if   req_bus ();
  xlf_flags_if flags_bus ();

  x86_lazy_flags_eval dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (flags_bus)
  );

  flags_t      expected_flags[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          steady_flow = 1'b0;

  always #(HalfPeriod) clk = ~clk;

  // Flag rules per operation, applied to the operands cut to the operand size.
  function automatic flags_t predict_flags(req_t op);
    logic [15:0] mask;
    logic [15:0] sign;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    flags_t      f;
    mask = op.wide ? MaskWord : MaskByte;
    sign = op.wide ? SignWord : SignByte;
    a    = op.first_operand & mask;
    b    = op.second_operand & mask;
    r    = op.op_result & mask;
    f    = '0;
    case (op.req_type)
      OP_ADD, OP_ADC: begin
        f.carry_flag     = (op.req_type == OP_ADD) ? (r < a) : (r <= a);
        f.aux_carry_flag = a[AuxBit] ^ b[AuxBit] ^ r[AuxBit];
        f.overflow_flag  = |(~(a ^ b) & (b ^ r) & sign);
      end
      OP_SUB, OP_SBB: begin
        f.carry_flag     = (op.req_type == OP_SUB) ? (a < b) : ((a < r) || (b == mask));
        f.aux_carry_flag = a[AuxBit] ^ b[AuxBit] ^ r[AuxBit];
        f.overflow_flag  = |((a ^ b) & (a ^ r) & sign);
      end
      OP_NEG: begin
        f.carry_flag     = (r != '0);
        f.aux_carry_flag = (r[3:0] != 4'h0);
        f.overflow_flag  = (r == sign);
      end
      OP_INC: begin
        f.aux_carry_flag = (r[3:0] == 4'h0);
        f.overflow_flag  = (r == sign);
      end
      OP_DEC: begin
        f.aux_carry_flag = (r[3:0] == NibbleAll);
        f.overflow_flag  = (r == (op.wide ? MaxWord : MaxByte));
      end
      OP_DAA: begin
        f.carry_flag     = (a != '0);
        f.aux_carry_flag = (b != '0);
      end
      default: begin
      end
    endcase
    f.parity_flag = ~^r[7:0];
    f.zero_flag   = (r == '0);
    f.sign_flag   = |(r & sign);
    return f;
  endfunction

  // Operands lean toward the boundary values of the chosen size.
  function automatic logic [15:0] pick_operand(logic wide);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return MaskWord;
      2: return wide ? SignWord : SignByte;
      3: return wide ? MaxWord : MaxByte;
      4: return 16'($urandom_range(0, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly requests whose result really follows from the operands; the rest are raw.
  function automatic req_t random_request();
    req_t        item;
    logic        carry_in;
    int unsigned pick;
    pick     = $urandom_range(0, 19);
    carry_in = 1'($urandom_range(0, 1));
    item.req_type       = (pick < 16) ? 4'(pick % 8) : 4'($urandom_range(OpOther, OpTop));
    item.wide           = 1'($urandom_range(0, 1));
    item.first_operand  = pick_operand(item.wide);
    item.second_operand = pick_operand(item.wide);
    item.op_result      = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      case (item.req_type)
        OP_ADD: item.op_result = item.first_operand + item.second_operand;
        OP_ADC: item.op_result = item.first_operand + item.second_operand + carry_in;
        OP_SUB: item.op_result = item.first_operand - item.second_operand;
        OP_SBB: item.op_result = item.first_operand - item.second_operand - carry_in;
        OP_NEG: item.op_result = 16'h0000 - item.first_operand;
        OP_INC: item.op_result = item.first_operand + 16'd1;
        OP_DEC: item.op_result = item.first_operand - 16'd1;
        OP_DAA: begin
          item.first_operand  = 16'(carry_in);
          item.second_operand = 16'($urandom_range(0, 1));
        end
        default: begin
        end
      endcase
    end
    // Byte operations get random upper bytes half of the time.
    if (!item.wide && $urandom_range(0, 1) == 1) begin
      item.first_operand[15:8]  = 8'($urandom);
      item.second_operand[15:8] = 8'($urandom);
      item.op_result[15:8]      = 8'($urandom);
    end
    return item;
  endfunction

  // Drive one request after a random gap (none in steady flow) and hold it until it is taken.
  task automatic send_request(req_t item);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MaxWait);
    repeat (gap) @(negedge clk) req_bus.valid <= 1'b0;
    @(negedge clk);
    req_bus.valid          <= 1'b1;
    req_bus.req_type       <= item.req_type;
    req_bus.wide           <= item.wide;
    req_bus.first_operand  <= item.first_operand;
    req_bus.second_operand <= item.second_operand;
    req_bus.op_result      <= item.op_result;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic send_op(logic [3:0] kind, logic wide, logic [15:0] a, logic [15:0] b,
                         logic [15:0] r);
    req_t item;
    item = '{req_type: kind, wide: wide, first_operand: a, second_operand: b, op_result: r};
    send_request(item);
  endtask

  task automatic check_flag(string name, logic want, logic got);
    if (want !== got) begin
      error_count++;
      $error("%s mismatch: expected %0b, actual %0b", name, want, got);
    end
  endtask

  // Boundary values of every operation at both sizes.
  task automatic test_directed_corners();
    send_op(OP_ADD, 1'b0, 16'h007F, 16'h0001, 16'h0080);
    send_op(OP_ADD, 1'b0, 16'hABFF, 16'h5501, 16'hFF00);
    send_op(OP_ADD, 1'b1, 16'hFFFF, 16'h0001, 16'h0000);
    send_op(OP_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(OP_ADC, 1'b0, 16'h0010, 16'h00FF, 16'h0010);
    send_op(OP_ADC, 1'b1, 16'h7FFF, 16'h0000, 16'h8000);
    send_op(OP_SUB, 1'b0, 16'h0000, 16'h0001, 16'h00FF);
    send_op(OP_SUB, 1'b1, 16'h8000, 16'h0001, 16'h7FFF);
    send_op(OP_SUB, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_SBB, 1'b0, 16'h0000, 16'h00FF, 16'h0000);
    send_op(OP_SBB, 1'b1, 16'h0001, 16'h0001, 16'hFFFF);
    send_op(OP_NEG, 1'b0, 16'h0080, 16'h0000, 16'h0080);
    send_op(OP_NEG, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_INC, 1'b0, 16'h007F, 16'h0000, 16'h0080);
    send_op(OP_INC, 1'b1, 16'hFFFF, 16'h0000, 16'h0000);
    send_op(OP_INC, 1'b0, 16'h00FF, 16'h1200, 16'hFF00);
    send_op(OP_DEC, 1'b0, 16'h0080, 16'h0000, 16'h007F);
    send_op(OP_DEC, 1'b1, 16'h8000, 16'h0000, 16'h7FFF);
    send_op(OP_DEC, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    // Carry values above the byte are dropped for a byte-sized adjust.
    send_op(OP_DAA, 1'b0, 16'h0100, 16'h0001, 16'h0099);
    send_op(OP_DAA, 1'b1, 16'h0001, 16'h0000, 16'h0000);
    send_op(OpOther, 1'b1, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_op(OpTop, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_op(OpOther + 4'd1, 1'b0, 16'h00FF, 16'h00FF, 16'h0003);
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (BurstItems) send_request(random_request());
    steady_flow = 1'b0;
  endtask

  // Random requests, with phases of idling and phases at full rate.
  task automatic test_random_mix();
    for (int unsigned i = 0; i < MixItems; i++) begin
      if (i % PhaseLength == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      send_request(random_request());
    end
    steady_flow = 1'b0;
  endtask

  // The flags side waits a random number of cycles before taking each result, except in steady flow.
  initial begin
    int unsigned stall;
    flags_bus.ready = 1'b0;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MaxWait);
      repeat (stall) @(negedge clk) flags_bus.ready <= 1'b0;
      @(negedge clk) flags_bus.ready <= 1'b1;
      do @(posedge clk); while (!(flags_bus.valid && !rst));
    end
  end

  // Record each accepted request and check each accepted result in order.
  always @(posedge clk) begin : flag_monitor
    req_t   seen;
    flags_t got;
    flags_t want;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        seen = '{req_type: req_bus.req_type, wide: req_bus.wide,
                 first_operand: req_bus.first_operand,
                 second_operand: req_bus.second_operand, op_result: req_bus.op_result};
        expected_flags.push_back(predict_flags(seen));
      end
      if (flags_bus.valid && flags_bus.ready) begin
        got = '{carry_flag: flags_bus.carry_flag, parity_flag: flags_bus.parity_flag,
                aux_carry_flag: flags_bus.aux_carry_flag, zero_flag: flags_bus.zero_flag,
                sign_flag: flags_bus.sign_flag, overflow_flag: flags_bus.overflow_flag};
        if (expected_flags.size() == 0) begin
          error_count++;
          $error("flags result arrived with no request outstanding");
        end else begin
          want = expected_flags.pop_front();
          check_flag("carry_flag", want.carry_flag, got.carry_flag);
          check_flag("parity_flag", want.parity_flag, got.parity_flag);
          check_flag("aux_carry_flag", want.aux_carry_flag, got.aux_carry_flag);
          check_flag("zero_flag", want.zero_flag, got.zero_flag);
          check_flag("sign_flag", want.sign_flag, got.sign_flag);
          check_flag("overflow_flag", want.overflow_flag, got.overflow_flag);
        end
      end
    end
  end

  // Stop the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (flags_bus.valid && flags_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_bus.valid          = 1'b0;
    req_bus.req_type       = '0;
    req_bus.wide           = 1'b0;
    req_bus.first_operand  = '0;
    req_bus.second_operand = '0;
    req_bus.op_result      = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_corners();
    test_back_to_back();
    test_random_mix();

    @(negedge clk) req_bus.valid <= 1'b0;
    wait (expected_flags.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/xlf_pkg.sv
rtl/xlf_ifs.sv
rtl/xlf_flag_calc.sv
rtl/x86_lazy_flags_eval.sv
rtl/xlf_checker.sv
bench/testbench.sv
